// ===== rtl/ddff_pkg.sv =====
// ----------------------------------------------------------------------------
// ddff_pkg - shared types and constants of the feedforward voltage datapath
// Register indexes, configuration bundle and the pipelined divider stage.
// ----------------------------------------------------------------------------
package ddff_pkg;

  // Magnitude width of the interpolation dividend and width of the divisor
  localparam int DIVW = 34;
  localparam int DW   = 17;

  localparam logic [15:0] GAIN_RESET = 16'd256;

  typedef enum logic [2:0] {
    CFG_VEL_POINTS  = 3'd0,
    CFG_VOLT_POINTS = 3'd1,
    CFG_TQ_GAIN     = 3'd2,
    CFG_HALF_WIDTH  = 3'd3,
    CFG_INERTIA     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] vel_pts;
    logic [63:0] volt_pts;
    logic [15:0] gain;
  } wheel_cfg_t;

  // Data that rides along the divider untouched
  typedef struct packed {
    logic signed [31:0] base;   // hold-point voltage plus torque term
    logic               flat;   // zero-width or descending segment
    logic               neg;    // dividend was negative, floor via complement
  } div_side_t;

  typedef struct packed {
    logic [DIVW-1:0] m;
    logic [DIVW-1:0] q;
    logic [DW-1:0]   r;
    logic [DW-1:0]   d;
    div_side_t       side;
  } div_stage_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t  o;
    logic [DW:0] t;
    o = s;
    t = {s.r, s.m[DIVW-1]};
    o.m = {s.m[DIVW-2:0], 1'b0};
    if (t >= {1'b0, s.d}) begin
      o.r = DW'(t - {1'b0, s.d});
      o.q = {s.q[DIVW-2:0], 1'b1};
    end else begin
      o.r = t[DW-1:0];
      o.q = {s.q[DIVW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/ddff_div.sv =====
// ----------------------------------------------------------------------------
// ddff_div - pipelined restoring divider
// One quotient bit per stage, DIVW stages, sideband carried along.
// ----------------------------------------------------------------------------
module ddff_div
  import ddff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  div_stage_t in_stage,
  output logic       out_valid,
  output div_stage_t out_stage
);

  div_stage_t stage_r [DIVW];
  logic       valid_r [DIVW];

  for (genvar s = 0; s < DIVW; s++) begin : g_stage
    div_stage_t cur;
    logic       cur_valid;

    if (s == 0) begin : g_head
      assign cur       = in_stage;
      assign cur_valid = in_valid;
    end else begin : g_body
      assign cur       = stage_r[s-1];
      assign cur_valid = valid_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[s] <= div_step(cur);
      end
    end
  end

  assign out_valid = valid_r[DIVW-1];
  assign out_stage = stage_r[DIVW-1];

endmodule

// ===== rtl/ddff_wheel.sv =====
// ----------------------------------------------------------------------------
// ddff_wheel - per-wheel hold-voltage interpolation and torque term
// Clamp, segment pick, slope product, divide, sum and saturate.
// ----------------------------------------------------------------------------
module ddff_wheel
  import ddff_pkg::*;
#(
  parameter int NPOINTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [18:0] vel,
  input  logic signed [22:0] torque,
  input  wheel_cfg_t         cfg,
  output logic               out_valid,
  output logic signed [15:0] voltage
);

  // Stage A: clamp velocity, torque times gain
  logic signed [15:0] lo, hi;
  logic signed [18:0] lo_x, hi_x, xs;
  logic signed [15:0] x_r;
  logic signed [39:0] prod_nxt, prod_r;
  logic               va_r;

  always_comb begin
    lo   = cfg.vel_pts[15:0];
    hi   = cfg.vel_pts[16*(NPOINTS-1) +: 16];
    lo_x = {{3{lo[15]}}, lo};
    hi_x = {{3{hi[15]}}, hi};
    xs   = (vel > hi_x) ? hi_x : vel;
    xs   = (xs < lo_x) ? lo_x : xs;
    prod_nxt = torque * $signed({1'b0, cfg.gain});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= xs[15:0];
      prod_r <= prod_nxt;
    end
  end

  // Stage B: pick segment, offsets, round torque term
  logic signed [15:0] xp [NPOINTS];
  logic signed [15:0] yp [NPOINTS];
  logic signed [15:0] x0, x1, y0, y1;
  logic               found;
  logic signed [40:0] tv_sum;
  logic signed [16:0] xo_r, dx_r, dy_r;
  logic signed [15:0] y0_r;
  logic signed [30:0] tv_r;
  logic               vb_r;

  always_comb begin
    for (int k = 0; k < NPOINTS; k++) begin
      xp[k] = cfg.vel_pts[16*k +: 16];
      yp[k] = cfg.volt_pts[16*k +: 16];
    end
  end

  always_comb begin
    found = 1'b0;
    x0 = xp[NPOINTS-2];
    x1 = xp[NPOINTS-1];
    y0 = yp[NPOINTS-2];
    y1 = yp[NPOINTS-1];
    for (int k = 1; k < NPOINTS; k++) begin
      if (!found && (x_r <= xp[k])) begin
        found = 1'b1;
        x0 = xp[k-1];
        x1 = xp[k];
        y0 = yp[k-1];
        y1 = yp[k];
      end
    end
    tv_sum = {prod_r[39], prod_r} + 41'sd512;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xo_r <= {x_r[15], x_r} - {x0[15], x0};
      dx_r <= {x1[15], x1} - {x0[15], x0};
      dy_r <= {y1[15], y1} - {y0[15], y0};
      y0_r <= y0;
      tv_r <= tv_sum[40:10];
    end
  end

  // Stage C: slope numerator, base voltage
  logic signed [33:0] num_r;
  logic signed [16:0] dxc_r;
  logic signed [31:0] base_r;
  logic               flat_r;
  logic               vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= xo_r * dy_r;
      dxc_r  <= dx_r;
      flat_r <= (dx_r <= 17'sd0);
      base_r <= {{16{y0_r[15]}}, y0_r} + {tv_r[30], tv_r};
    end
  end

  // Stage D: rounded dividend 2*num+dx, folded to a magnitude for floor division
  logic signed [35:0] n_val;
  logic [35:0]        n_mag;
  div_stage_t         div_nxt, div_in_r;
  logic               vd_r;

  always_comb begin
    n_val = {num_r[33], num_r, 1'b0} + {{19{dxc_r[16]}}, dxc_r};
    n_mag = n_val ^ {36{n_val[35]}};
    div_nxt.m         = n_mag[DIVW-1:0];
    div_nxt.q         = '0;
    div_nxt.r         = '0;
    div_nxt.d         = {dxc_r[15:0], 1'b0};
    div_nxt.side.base = base_r;
    div_nxt.side.flat = flat_r;
    div_nxt.side.neg  = n_val[35];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_in_r <= div_nxt;
    end
  end

  div_stage_t div_out;
  logic       div_valid;

  ddff_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vd_r),
    .in_stage  (div_in_r),
    .out_valid (div_valid),
    .out_stage (div_out)
  );

  // Final: floor quotient, add base, saturate
  logic signed [34:0] q_s;
  logic signed [35:0] sum;

  always_comb begin
    q_s = div_out.side.neg ? ~{1'b0, div_out.q} : {1'b0, div_out.q};
    if (div_out.side.flat) begin
      q_s = '0;
    end
    sum = {{4{div_out.side.base[31]}}, div_out.side.base} + {q_s[34], q_s};
    if (sum > 36'sd32767) begin
      voltage = 16'sh7fff;
    end else if (sum < -36'sd32768) begin
      voltage = 16'sh8000;
    end else begin
      voltage = sum[15:0];
    end
  end

  assign out_valid = div_valid;

endmodule

// ===== rtl/diff_drive_feedforward_voltage.sv =====
// ----------------------------------------------------------------------------
// diff_drive_feedforward_voltage - differential drive feedforward voltages
// Body velocity and acceleration in, left and right wheel voltages out.
// ----------------------------------------------------------------------------
// Takes one beat per clock with no gaps needed while in_tready is high: the
// datapath is a 41-stage pipeline (two body stages, four per-wheel stages, a
// 34-stage restoring divider that yields one quotient bit per stage for the
// interpolation slope, one output register), and one result leaves per cycle
// in steady state while the sink takes them. An output register plus
// a one-entry skid stage decouples the sides: in_tready drops only when
// both hold a result that the sink has not taken. Configuration is plain
// flops with no clearing pass; write it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module diff_drive_feedforward_voltage
  import ddff_pkg::*;
#(
  parameter int NPOINTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // linear_velocity[15:0], angular_velocity[31:16],
  // linear_accel[47:32], angular_accel[63:48]
  input  logic [63:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // left_voltage[15:0], right_voltage[31:16]
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  // Configuration registers
  logic [63:0] vel_pts_r, volt_pts_r;
  logic [15:0] gain_r, half_width_r, inertia_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_pts_r    <= '0;
      volt_pts_r   <= '0;
      gain_r       <= GAIN_RESET;
      half_width_r <= '0;
      inertia_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_VEL_POINTS:  vel_pts_r    <= cfg_wdata;
        CFG_VOLT_POINTS: volt_pts_r   <= cfg_wdata;
        CFG_TQ_GAIN:     gain_r       <= cfg_wdata[15:0];
        CFG_HALF_WIDTH:  half_width_r <= cfg_wdata[15:0];
        CFG_INERTIA:     inertia_r    <= cfg_wdata[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  wheel_cfg_t wcfg;
  assign wcfg.vel_pts  = vel_pts_r;
  assign wcfg.volt_pts = volt_pts_r;
  assign wcfg.gain     = gain_r;

  // Global advance: hold every stage while the skid entry is occupied
  logic skid_valid_r;
  logic en;
  assign en        = !skid_valid_r;
  assign in_tready = en;

  logic signed [15:0] in_v, in_w, in_a, in_al;
  assign in_v  = in_tdata[15:0];
  assign in_w  = in_tdata[31:16];
  assign in_a  = in_tdata[47:32];
  assign in_al = in_tdata[63:48];

  // Stage 1: yaw rate times half width, yaw accel times inertia factor
  logic signed [32:0] wb_r, ai_r;
  logic signed [15:0] v1_r, a1_r;
  logic               v1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_valid_r <= 1'b0;
    end else if (en) begin
      v1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wb_r <= in_w * $signed({1'b0, half_width_r});
      ai_r <= in_al * $signed({1'b0, inertia_r});
      v1_r <= in_v;
      a1_r <= in_a;
    end
  end

  // Stage 2: round the differential terms (add half, floor), split per wheel
  logic signed [33:0] dv_sum, dt_sum;
  logic signed [17:0] dv;
  logic signed [21:0] dt;
  logic signed [18:0] vel_l_r, vel_r_r;
  logic signed [22:0] tq_l_r, tq_r_r;
  logic               v2_valid_r;

  always_comb begin
    dv_sum = {wb_r[32], wb_r} + 34'sd32768;
    dt_sum = {ai_r[32], ai_r} + 34'sd2048;
    dv     = dv_sum[33:16];
    dt     = dt_sum[33:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_valid_r <= 1'b0;
    end else if (en) begin
      v2_valid_r <= v1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_l_r <= {{3{v1_r[15]}}, v1_r} - {dv[17], dv};
      vel_r_r <= {{3{v1_r[15]}}, v1_r} + {dv[17], dv};
      tq_l_r  <= {{7{a1_r[15]}}, a1_r} - {dt[21], dt};
      tq_r_r  <= {{7{a1_r[15]}}, a1_r} + {dt[21], dt};
    end
  end

  // Per-wheel interpolation pipelines
  logic               l_valid, r_valid;
  logic signed [15:0] l_volt, r_volt;

  ddff_wheel #(.NPOINTS(NPOINTS)) u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_valid_r),
    .vel       (vel_l_r),
    .torque    (tq_l_r),
    .cfg       (wcfg),
    .out_valid (l_valid),
    .voltage   (l_volt)
  );

  ddff_wheel #(.NPOINTS(NPOINTS)) u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_valid_r),
    .vel       (vel_r_r),
    .torque    (tq_r_r),
    .cfg       (wcfg),
    .out_valid (r_valid),
    .voltage   (r_volt)
  );

  // Output register and skid entry. While the pipeline advances, its last
  // stage always lands in one of them: the output register if free or being
  // taken, the skid entry otherwise. The skid entry then stalls the pipeline.
  logic        p_valid;
  logic [31:0] p_data;
  logic [31:0] out_data_r, skid_data_r;
  logic        out_valid_r;

  assign p_valid = l_valid & r_valid;
  assign p_data  = {r_volt, l_volt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (en && p_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (en && p_valid) begin
        skid_data_r <= p_data;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else begin
      out_data_r <= p_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/ddff_checker.sv =====
// ----------------------------------------------------------------------------
// ddff_checker - port-level checks for the feedforward voltage block
// Bound to the top level; watches the stream and backpressure behavior.
// ----------------------------------------------------------------------------
module ddff_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic [31:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // A stalled result beat stays and keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Input backpressure only ever comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // Draining the held result reopens the input on the next cycle
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("input still stalled after result was taken");

  // Leaving reset, nothing is offered downstream and the input is open
  a_reset_clean: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid && in_tready)
    else $error("stale state after reset");

endmodule

bind diff_drive_feedforward_voltage ddff_checker u_ddff_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for the differential drive feedforward voltages
// Drives body velocity and acceleration beats into the block, predicts the
// left and right wheel voltages for every accepted beat, and compares each
// result beat field by field in order. Runs directed corner beats under
// several register settings, then random settings with random traffic,
// random gaps on both sides and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddff_pkg::*;

  localparam int NPTS          = 4;
  localparam int PIPE_LATENCY  = 41;
  localparam int HOLDOFF_BEATS = 300;
  localparam int RAND_PHASES   = 8;
  localparam int RAND_BEATS    = 166;
  localparam int MAX_REPORTS   = 10;

  // --------------------------------------------------------------------------
  // Expected wheel voltages: predictor plus in-order store of pending results
  // --------------------------------------------------------------------------
  class voltage_scoreboard;
    logic [63:0] vel_pts;
    logic [63:0] volt_pts;
    logic [15:0] gain;
    logic [15:0] half_width;
    logic [15:0] inertia;
    logic [31:0] expected_volts[$];
    int          errors;

    function new();
      vel_pts    = '0;
      volt_pts   = '0;
      gain       = GAIN_RESET;
      half_width = '0;
      inertia    = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_VEL_POINTS:  vel_pts    = data;
        CFG_VOLT_POINTS: volt_pts   = data;
        CFG_TQ_GAIN:     gain       = data[15:0];
        CFG_HALF_WIDTH:  half_width = data[15:0];
        CFG_INERTIA:     inertia    = data[15:0];
        default: ;
      endcase
    endfunction

    function longint point(logic [63:0] pts, int k);
      return longint'($signed(pts[16*k +: 16]));
    endfunction

    // add half, then floor
    function longint round_shift(longint x, int s);
      longint one;
      one = 1;
      return (x + (one <<< (s - 1))) >>> s;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    // clamp, pick the segment, interpolate with round-half-up
    function longint hold_volts(longint vel);
      longint x, x0, x1, y0, y1, dx, num;
      int     seg;
      bit     found;
      x     = vel;
      seg   = NPTS - 1;
      found = 0;
      if (x > point(vel_pts, NPTS - 1)) x = point(vel_pts, NPTS - 1);
      if (x < point(vel_pts, 0)) x = point(vel_pts, 0);
      for (int k = 1; k < NPTS; k++) begin
        if (!found && x <= point(vel_pts, k)) begin
          seg   = k;
          found = 1;
        end
      end
      x0 = point(vel_pts, seg - 1);
      x1 = point(vel_pts, seg);
      y0 = point(volt_pts, seg - 1);
      y1 = point(volt_pts, seg);
      dx = x1 - x0;
      if (dx <= 0) return y0;
      num = (x - x0) * (y1 - y0);
      return y0 + floor_div(2 * num + dx, 2 * dx);
    endfunction

    function logic [15:0] wheel_volts(longint vel, longint torque);
      longint sum;
      sum = hold_volts(vel) + round_shift(torque * longint'(gain), 10);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      return sum[15:0];
    endfunction

    function void note_command(logic [63:0] beat);
      longint v, w, a, al, dv, dt;
      v  = longint'($signed(beat[15:0]));
      w  = longint'($signed(beat[31:16]));
      a  = longint'($signed(beat[47:32]));
      al = longint'($signed(beat[63:48]));
      dv = round_shift(w * longint'(half_width), 16);
      dt = round_shift(al * longint'(inertia), 12);
      expected_volts.push_back({wheel_volts(v + dv, a + dt), wheel_volts(v - dv, a - dt)});
    endfunction

    function void check_voltages(logic [31:0] beat);
      logic [31:0] exp_volts;
      if (expected_volts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result beat: left %0d right %0d",
                   $signed(beat[15:0]), $signed(beat[31:16]));
        return;
      end
      exp_volts = expected_volts.pop_front();
      if (exp_volts[15:0] !== beat[15:0] || exp_volts[31:16] !== beat[31:16]) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("voltage mismatch: exp left %0d right %0d, got left %0d right %0d",
                   $signed(exp_volts[15:0]), $signed(exp_volts[31:16]),
                   $signed(beat[15:0]), $signed(beat[31:16]));
      end
    endfunction

    function int outstanding();
      return expected_volts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic [63:0] in_tdata  = '0;    // linear_velocity, angular_velocity, linear_accel, angular_accel
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;         // left_voltage, right_voltage
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [63:0] cfg_wdata  = '0;

  voltage_scoreboard sb;

  // Idle controls shared between the stimulus and the sink
  bit tx_idle;
  bit rx_idle;
  bit stall_req;

  always #2 clk = ~clk;

  diff_drive_feedforward_voltage #(
    .NPOINTS(NPTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pack_cmd(logic [15:0] v, logic [15:0] w,
                                           logic [15:0] a, logic [15:0] al);
    return {al, a, w, v};
  endfunction

  // Four random breakpoints sorted ascending; optionally force a zero-width segment
  function automatic logic [63:0] sorted_points(int spread, bit dup);
    logic signed [15:0] p[NPTS];
    logic signed [15:0] t;
    logic [63:0]        packed_pts;
    for (int k = 0; k < NPTS; k++)
      p[k] = $signed(16'($urandom_range(0, 2 * spread))) - 16'(spread);
    if (dup) p[1] = p[2];
    for (int i = 0; i < NPTS - 1; i++)
      for (int j = 0; j < NPTS - 1 - i; j++)
        if (p[j] > p[j + 1]) begin
          t        = p[j];
          p[j]     = p[j + 1];
          p[j + 1] = t;
        end
    for (int k = 0; k < NPTS; k++) packed_pts[16*k +: 16] = p[k];
    return packed_pts;
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks; each starts and ends on a falling edge
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Write every register, then poke an unmapped index with junk that must be ignored.
  // With junk set, the unused upper bits of the 16-bit registers carry noise too.
  task automatic load_config(input logic [63:0] vel, input logic [63:0] volt,
                             input logic [15:0] gain, input logic [15:0] hw,
                             input logic [15:0] inert, input bit junk);
    logic [47:0] upper;
    upper = junk ? 48'({$urandom, $urandom}) : '0;
    write_reg(CFG_VEL_POINTS, vel);
    write_reg(CFG_VOLT_POINTS, volt);
    write_reg(CFG_TQ_GAIN, {upper, gain});
    write_reg(CFG_HALF_WIDTH, {upper, hw});
    write_reg(CFG_INERTIA, {upper, inert});
    write_reg(3'(CFG_INERTIA) + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one command beat, hold it until accepted, note it for prediction.
  // Valid is lowered only when a gap is inserted, so back-to-back beats keep it high.
  task automatic send_cmd(input logic [63:0] beat);
    int gap;
    gap = (tx_idle && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= beat;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_command(beat);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected voltage, then let the pipe go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 8) @(negedge clk);
  endtask

  // Random command beats: velocity often steered near a breakpoint, rates and
  // accelerations either full range or small so that not every wheel saturates
  task automatic run_random(input int n);
    logic [15:0] v, w, a, al;
    int          k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) begin
        k = $urandom_range(0, NPTS - 1);
        v = sb.vel_pts[16*k +: 16] + 16'($urandom_range(0, 512)) - 16'd256;
      end else begin
        v = 16'($urandom);
      end
      w  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2047)) - 16'd1024;
      a  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4095)) - 16'd2048;
      al = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4095)) - 16'd2048;
      send_cmd(pack_cmd(v, w, a, al));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sink: random ready with short and long stalls, plus one long hold-off
  // counted here so the block fills up and pushes back on its input
  // --------------------------------------------------------------------------
  initial begin : sink
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 0;
        hold      = HOLDOFF_BEATS;
      end else if (hold == 0 && rx_idle && $urandom_range(0, 99) < 15) begin
        hold = gap_len();
      end
      out_tready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  // Check every result beat at the rising edge it is taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_voltages(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] vel, volt;
    logic [15:0] gain, hw, inert;
    int          mode;

    sb        = new();
    tx_idle   = 0;
    rx_idle   = 0;
    stall_req = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: flat zero table, gain of 256 (a quarter after the 10-bit shift); only the torque term shows
    send_cmd(pack_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(pack_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_cmd(pack_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_cmd(pack_cmd(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
    settle();

    // Ascending table: hit each breakpoint, the gaps between, and both clamps
    load_config({16'h3000, 16'h0800, 16'hF800, 16'hD000},
                {16'h2000, 16'h0400, 16'hFC00, 16'hE000},
                16'h0180, 16'h4000, 16'h0800, 1'b0);
    rx_idle = 1;
    send_cmd(pack_cmd(16'hD000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(pack_cmd(16'hF800, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(pack_cmd(16'h0800, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(pack_cmd(16'h3000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(pack_cmd(16'h8000, 16'h0000, 16'h1000, 16'h0000));
    send_cmd(pack_cmd(16'h7FFF, 16'h0000, 16'hF000, 16'h0000));
    send_cmd(pack_cmd(16'h0123, 16'h7FFF, 16'h0000, 16'h8000));
    send_cmd(pack_cmd(16'hFEDC, 16'h8000, 16'h0000, 16'h7FFF));
    settle();

    // Full-scale registers: widest table, largest gain, width and inertia;
    // drives both rails of the saturation
    load_config({16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000},
                {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    tx_idle = 1;
    send_cmd(pack_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_cmd(pack_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_cmd(pack_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h8000));
    send_cmd(pack_cmd(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF));
    send_cmd(pack_cmd(16'h4000, 16'h8000, 16'h7FFF, 16'h0001));
    settle();

    // Table out of order: first point above the last, a zero-width and a
    // descending segment; zero gain, width and inertia
    load_config({16'hF000, 16'h0800, 16'h1000, 16'h1000},
                {16'h0C00, 16'hF400, 16'h0200, 16'h0600},
                16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_cmd(pack_cmd(16'h0000, 16'h0000, 16'h7FFF, 16'h0000));
    send_cmd(pack_cmd(16'h1000, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(pack_cmd(16'h9000, 16'h0000, 16'h0000, 16'h7FFF));
    send_cmd(pack_cmd(16'h7000, 16'h0000, 16'h8000, 16'h0000));
    send_cmd(pack_cmd(16'h0900, 16'h0000, 16'h0000, 16'h0000));
    settle();

    // Random settings; the first phase runs flat out against the long hold-off
    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = $urandom_range(0, 4);
      case (mode)
        0, 1:    vel = sorted_points(32767, 1'b0);
        2:       vel = sorted_points(2048, 1'b0);
        3:       vel = sorted_points(16384, 1'b1);
        default: vel = {$urandom, $urandom};
      endcase
      volt = $urandom_range(0, 1) ? {$urandom, $urandom} : sorted_points(4096, 1'b0);
      case ($urandom_range(0, 7))
        0:       gain = 16'h0000;
        1:       gain = 16'hFFFF;
        default: gain = 16'($urandom_range(0, 1023));
      endcase
      hw    = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
      inert = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
      load_config(vel, volt, gain, hw, inert, 1'($urandom_range(0, 1)));
      if (p == 0) begin
        tx_idle   = 0;
        rx_idle   = 0;
        stall_req = 1;
      end else begin
        tx_idle = (p % 3) != 0;
        rx_idle = (p % 4) != 2;
      end
      run_random(RAND_BEATS);
      settle();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
